@@ rtl/core/cvtn_pkg.sv @@
// Shared types and codes for the class value table with nearest lookup.
// Used by cvtn_cell and class_value_table_nearest; no dependencies.
package cvtn_pkg;

  // Action codes; any action with bit 1 set clears the table
  localparam logic [1:0] ACT_LEARN    = 2'd0;
  localparam logic [1:0] ACT_CLASSIFY = 2'd1;

  // Result status codes
  localparam logic [2:0] ST_MATCHED = 3'd0;
  localparam logic [2:0] ST_ADDED   = 3'd1;
  localparam logic [2:0] ST_FULL    = 3'd2;
  localparam logic [2:0] ST_EMPTY   = 3'd3;
  localparam logic [2:0] ST_CLEARED = 3'd4;

  localparam int unsigned TOL_W  = 16;
  localparam int unsigned DIST_W = 33;

  // Input request payload
  typedef struct packed {
    logic [1:0]         action;
    logic signed [31:0] value;
  } cvtn_req_t;

  // Result payload
  typedef struct packed {
    logic signed [31:0] class_value;
    logic [5:0]         class_index;
    logic [2:0]         status;
    logic [6:0]         class_count;
  } cvtn_rsp_t;

  // Search token handed from cell to cell
  typedef struct packed {
    logic [1:0]          action;
    logic                hit;
    logic signed [31:0]  query;
    logic signed [31:0]  best_val;
    logic [DIST_W-1:0]   best_dist;
  } cvtn_tok_t;

endpackage

@@ rtl/core/cvtn_cell.sv @@
// One table cell: holds one class entry and updates the passing search token.
// Depends on cvtn_pkg for the token type and action codes.
module cvtn_cell #(
  parameter int unsigned IDX_W    = 6,
  parameter int unsigned CNT_W    = 7,
  parameter int unsigned CELL_IDX = 0
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic [CNT_W-1:0]           count_i,
  input  logic [cvtn_pkg::TOL_W-1:0] tol_i,
  input  logic                       wr_en_i,
  input  logic signed [31:0]         wr_data_i,
  input  logic                       vld_i,
  input  cvtn_pkg::cvtn_tok_t        tok_i,
  input  logic [IDX_W-1:0]           idx_i,
  output logic                       vld_o,
  output cvtn_pkg::cvtn_tok_t        tok_o,
  output logic [IDX_W-1:0]           idx_o
);

  logic signed [31:0]              entry_q;
  logic                            vld_q;
  cvtn_pkg::cvtn_tok_t             tok_q, tok_d;
  logic [IDX_W-1:0]                idx_q, idx_d;
  logic                            active;
  logic signed [cvtn_pkg::DIST_W-1:0] diff;
  logic [cvtn_pkg::DIST_W-1:0]     gap_abs;
  logic                            near;

  // Hold the stored class value
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      entry_q <= wr_data_i;
    end
  end

  // Exact 33-bit distance to the query
  assign active  = (CNT_W'(CELL_IDX) < count_i);
  assign diff    = {entry_q[31], entry_q} - {tok_i.query[31], tok_i.query};
  assign gap_abs = diff[cvtn_pkg::DIST_W-1] ? cvtn_pkg::DIST_W'(-diff)
                                            : cvtn_pkg::DIST_W'(diff);
  assign near    = (gap_abs < {{(cvtn_pkg::DIST_W-cvtn_pkg::TOL_W){1'b0}}, tol_i});

  // Update the token: first match for learn, strict nearest for classify
  always_comb begin
    tok_d = tok_i;
    idx_d = idx_i;
    if (active) begin
      if (tok_i.action == cvtn_pkg::ACT_LEARN) begin
        if (!tok_i.hit && near) begin
          tok_d.hit      = 1'b1;
          tok_d.best_val = entry_q;
          tok_d.best_dist = gap_abs;
          idx_d          = IDX_W'(CELL_IDX);
        end
      end else if (tok_i.action == cvtn_pkg::ACT_CLASSIFY) begin
        if (!tok_i.hit || (gap_abs < tok_i.best_dist)) begin
          tok_d.hit       = 1'b1;
          tok_d.best_val  = entry_q;
          tok_d.best_dist = gap_abs;
          idx_d           = IDX_W'(CELL_IDX);
        end
      end
    end
  end

  // Advance the token valid to the next cell
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_i;
    end
  end

  // Advance the token payload
  always_ff @(posedge clk_i) begin
    tok_q <= tok_d;
    idx_q <= idx_d;
  end

  assign vld_o = vld_q;
  assign tok_o = tok_q;
  assign idx_o = idx_q;

endmodule

@@ rtl/core/class_value_table_nearest.sv @@
// One request is in flight at a time: a new request is accepted only after
// the last one finishes. The search token walks the cell row one cell per
// cycle, and the table is updated only at its end.
// Reset: table empty (count zero), tolerance 1; entries are not cleared.
// Top level of the class value table; depends on cvtn_pkg and cvtn_cell.
module class_value_table_nearest #(
  parameter int unsigned MAX_CLASSES = 64
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_valid_i,
  output logic                       cfg_ready_o,
  input  logic [cvtn_pkg::TOL_W-1:0] cfg_data_i,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  cvtn_pkg::cvtn_req_t        in_req_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output cvtn_pkg::cvtn_rsp_t        out_rsp_o
);

  localparam int unsigned IDX_W = $clog2(MAX_CLASSES);
  localparam int unsigned CNT_W = $clog2(MAX_CLASSES + 1);

  logic [cvtn_pkg::TOL_W-1:0] tol_q;
  logic [CNT_W-1:0]           count_q, count_d;
  logic                       busy_q;
  logic                       park_vld_q;
  cvtn_pkg::cvtn_tok_t        park_q;
  logic [IDX_W-1:0]           park_idx_q;
  logic                       out_valid_q;
  cvtn_pkg::cvtn_rsp_t        out_rsp_q, rsp_d;

  logic                       in_acc;
  logic                       fin;
  logic                       wr_add;
  logic [IDX_W-1:0]           add_idx;
  logic [IDX_W-1:0]           res_idx;
  logic [IDX_W+5:0]           idx_ext;
  logic [CNT_W+6:0]           cnt_ext;

  logic                       vld_c [0:MAX_CLASSES];
  cvtn_pkg::cvtn_tok_t        tok_c [0:MAX_CLASSES];
  logic [IDX_W-1:0]           idx_c [0:MAX_CLASSES];

  // Configuration register
  assign cfg_ready_o = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tol_q <= cvtn_pkg::TOL_W'(1);
    end else if (cfg_valid_i) begin
      tol_q <= cfg_data_i;
    end
  end

  // Inject a new request into the head of the row
  assign in_ready_o = !busy_q;
  assign in_acc     = in_valid_i && !busy_q;

  assign vld_c[0]           = in_acc;
  assign tok_c[0].action    = in_req_i.action;
  assign tok_c[0].hit       = 1'b0;
  assign tok_c[0].query     = in_req_i.value;
  assign tok_c[0].best_val  = '0;
  assign tok_c[0].best_dist = '0;
  assign idx_c[0]           = '0;

  // Row of table cells
  assign add_idx = count_q[IDX_W-1:0];
  for (genvar k = 0; k < MAX_CLASSES; k++) begin : g_cell
    cvtn_cell #(
      .IDX_W    (IDX_W),
      .CNT_W    (CNT_W),
      .CELL_IDX (k)
    ) u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .count_i   (count_q),
      .tol_i     (tol_q),
      .wr_en_i   (wr_add && (add_idx == IDX_W'(k))),
      .wr_data_i (park_q.query),
      .vld_i     (vld_c[k]),
      .tok_i     (tok_c[k]),
      .idx_i     (idx_c[k]),
      .vld_o     (vld_c[k+1]),
      .tok_o     (tok_c[k+1]),
      .idx_o     (idx_c[k+1])
    );
  end

  // Finish the request once the output slot is free
  assign fin = park_vld_q && (!out_valid_q || out_ready_i);

  always_comb begin
    rsp_d   = '0;
    count_d = count_q;
    wr_add  = 1'b0;
    res_idx = '0;
    if (park_q.action == cvtn_pkg::ACT_LEARN) begin
      if (park_q.hit) begin
        rsp_d.class_value = park_q.best_val;
        res_idx           = park_idx_q;
        rsp_d.status      = cvtn_pkg::ST_MATCHED;
      end else if (count_q == CNT_W'(MAX_CLASSES)) begin
        rsp_d.status = cvtn_pkg::ST_FULL;
      end else begin
        rsp_d.class_value = park_q.query;
        res_idx           = add_idx;
        rsp_d.status      = cvtn_pkg::ST_ADDED;
        count_d           = count_q + CNT_W'(1);
        wr_add            = fin;
      end
    end else if (park_q.action == cvtn_pkg::ACT_CLASSIFY) begin
      if (park_q.hit) begin
        rsp_d.class_value = park_q.best_val;
        res_idx           = park_idx_q;
        rsp_d.status      = cvtn_pkg::ST_MATCHED;
      end else begin
        rsp_d.status = cvtn_pkg::ST_EMPTY;
      end
    end else begin
      rsp_d.status = cvtn_pkg::ST_CLEARED;
      count_d      = '0;
    end
    idx_ext           = {6'd0, res_idx};
    cnt_ext           = {7'd0, count_d};
    rsp_d.class_index = idx_ext[5:0];
    rsp_d.class_count = cnt_ext[6:0];
  end

  // Control state: busy flag, parked token, count, output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      park_vld_q  <= 1'b0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_acc) begin
        busy_q <= 1'b1;
      end else if (fin) begin
        busy_q <= 1'b0;
      end
      if (vld_c[MAX_CLASSES]) begin
        park_vld_q <= 1'b1;
      end else if (fin) begin
        park_vld_q <= 1'b0;
      end
      if (fin) begin
        count_q     <= count_d;
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Hold the finished token and the result payload
  always_ff @(posedge clk_i) begin
    if (vld_c[MAX_CLASSES]) begin
      park_q     <= tok_c[MAX_CLASSES];
      park_idx_q <= idx_c[MAX_CLASSES];
    end
    if (fin) begin
      out_rsp_q <= rsp_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_rsp_q;

  // Checks
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(MAX_CLASSES))
    else $error("class count beyond table depth");

  a_park_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    park_vld_q |-> busy_q)
    else $error("parked token without a request in flight");

  a_fin_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fin |=> (out_valid_o && !park_vld_q))
    else $error("finished request did not reach the output");

  a_single_token: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_c[MAX_CLASSES] |-> !park_vld_q)
    else $error("second token reached the end of the row");

endmodule
